// ===== rtl/core/mrfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrfc_pkg
// Shared types and constants of the meter response frame checker.
// ----------------------------------------------------------------------------
package mrfc_pkg;

	localparam logic [7:0]  MAX_FRAME = 8'd128;
	localparam logic [7:0]  MIN_FRAME = 8'd23;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_SHORT     = 2'd1,
		ST_ADDR_ERR  = 2'd2,
		ST_CRC_ERR   = 2'd3
	} status_t;

	// byte offered to the frame accumulator
	typedef struct packed {
		logic       take;
		logic       last;
		logic [7:0] data;
	} acc_in_t;

	typedef struct packed {
		logic [15:0] alarm;
		logic [15:0] power_factor;
		logic [15:0] frequency;
		logic [31:0] energy;
		logic [31:0] power;
		logic [15:0] current;
		logic [15:0] voltage;
	} meas_t;

	typedef struct packed {
		status_t status;
		meas_t   meas;
	} result_t;

endpackage

// ===== rtl/core/mrfc_crc16.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrfc_crc16
// Byte-wide unrolled CRC-16 update, reflected polynomial.
// ----------------------------------------------------------------------------
module mrfc_crc16 (
	input  logic [15:0] crc_in,
	input  logic [7:0]  data,
	output logic [15:0] crc_out
);
	import mrfc_pkg::*;

	logic [15:0] c;

	always_comb begin
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end

endmodule

// ===== rtl/core/mrfc_frame_acc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrfc_frame_acc
// Per-frame state: byte count, running crc, address byte and field captures;
// forms the checked result from the updated state on the last word.
// ----------------------------------------------------------------------------
module mrfc_frame_acc (
	input  logic              clk,
	input  logic              arst_n,
	input  mrfc_pkg::acc_in_t acc_in,
	input  logic [7:0]        expected_address,
	output mrfc_pkg::result_t result
);
	import mrfc_pkg::*;

	logic [7:0]  count_q, count_n;
	logic [15:0] crc_q, crc_n, crc_step;
	logic [7:0]  first_q, first_n;
	meas_t       cap_q, cap_n;
	logic [7:0]  b;

	assign b = acc_in.data;

	mrfc_crc16 u_crc (
		.crc_in  (crc_q),
		.data    (b),
		.crc_out (crc_step)
	);

	always_comb begin
		count_n = count_q;
		crc_n   = crc_q;
		first_n = first_q;
		cap_n   = cap_q;
		// words past the frame limit are dropped
		if (count_q < MAX_FRAME) begin
			crc_n   = crc_step;
			count_n = count_q + 8'd1;
			case (count_q) inside
				8'd0:        first_n = b;
				[8'd3:8'd4]:   cap_n.voltage      = {cap_q.voltage[7:0], b};
				[8'd5:8'd6]:   cap_n.current      = {cap_q.current[7:0], b};
				[8'd7:8'd10]:  cap_n.power        = {cap_q.power[23:0], b};
				[8'd11:8'd14]: cap_n.energy       = {cap_q.energy[23:0], b};
				[8'd17:8'd18]: cap_n.frequency    = {cap_q.frequency[7:0], b};
				[8'd19:8'd20]: cap_n.power_factor = {cap_q.power_factor[7:0], b};
				[8'd21:8'd22]: cap_n.alarm        = {cap_q.alarm[7:0], b};
				default: ;
			endcase
		end
	end

	always_comb begin
		if (count_n < MIN_FRAME) begin
			result.status = ST_SHORT;
		end else if (first_n != expected_address) begin
			result.status = ST_ADDR_ERR;
		end else if (crc_n != 16'h0000) begin
			result.status = ST_CRC_ERR;
		end else begin
			result.status = ST_OK;
		end
		result.meas = (result.status == ST_OK) ? cap_n : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			crc_q   <= CRC_INIT;
			first_q <= '0;
			cap_q   <= '0;
		end else if (acc_in.take) begin
			if (acc_in.last) begin
				count_q <= '0;
				crc_q   <= CRC_INIT;
				first_q <= '0;
				cap_q   <= '0;
			end else begin
				count_q <= count_n;
				crc_q   <= crc_n;
				first_q <= first_n;
				cap_q   <= cap_n;
			end
		end
	end

endmodule

// ===== rtl/core/meter_response_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meter_response_frame_checker
// Checks Modbus RTU energy meter responses and extracts the raw readings.
// ----------------------------------------------------------------------------
// usage:
//  s_axis carries one frame byte per word, tlast on the final byte.
//  m_axis gives one word per frame: tuser is the status (ok, too short,
//  address mismatch, crc mismatch), tdata the big-endian readings, all zero
//  on any error. cfg_we/cfg_wdata set the expected slave address (reset 1);
//  write it only while no frame is in flight.
//  path: each byte is held in the input register; when the last byte leaves
//  it, its result loads the output register, which raises m_axis_tvalid.
//  throughput: one byte per cycle, except that a last byte waits while the
//  output register is not free; the crc is a byte-wide update between the
//  input register and the frame state.
//  stall: body bytes keep flowing while a result waits; only a last byte
//  waits in the input register until the output register is free.
//  reset: arst_n clears the frame state and both valid flags and sets the
//  address back to 1.
// ----------------------------------------------------------------------------
module meter_response_frame_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // rx_byte
	input  logic         s_axis_tlast,   // last_byte
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// voltage, current, power, energy, frequency, power_factor, alarm
	output logic [143:0] m_axis_tdata,
	output logic [1:0]   m_axis_tuser,   // status
	input  logic         cfg_we,
	input  logic [7:0]   cfg_wdata
);
	import mrfc_pkg::*;

	logic       valid_s1;
	logic       last_s1;
	logic [7:0] byte_s1;
	logic       adv;
	logic       res_load;
	logic       out_valid_q;
	result_t    out_q;
	result_t    result;
	acc_in_t    acc_in;
	logic [7:0] exp_addr_q;

	assign adv      = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign res_load = adv && last_s1;
	assign s_axis_tready = !valid_s1 || adv;

	assign acc_in.take = adv;
	assign acc_in.last = last_s1;
	assign acc_in.data = byte_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_addr_q <= 8'd1;
		end else if (cfg_we) begin
			exp_addr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	mrfc_frame_acc u_acc (
		.clk              (clk),
		.arst_n           (arst_n),
		.acc_in           (acc_in),
		.expected_address (exp_addr_q),
		.result           (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tdata  = out_q.meas;

`ifndef SYNTHESIS
	// a new result word only follows a last byte leaving the input register
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(valid_s1 && last_s1))
		else $error("result word without a last byte");

	// failed frames carry no readings
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
		else $error("readings not cleared on error status");

	// body bytes never wait on the result side
	a_body_flows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !last_s1) |-> s_axis_tready)
		else $error("body byte blocked by result stall");
`endif

endmodule

// ===== verif/tb_meter_response_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_meter_response_frame_checker
// Drives response frames, byte by byte, into the meter frame checker. A table
// of directed frames covers the length limits, the address and crc errors and
// the overlong case. Random frames follow, mostly well formed with random
// readings, under several slave addresses. Every result word is compared with
// a local frame decoder, or with the known status of a typed table row. Both
// stream sides idle at random, and one long receiver hold backs the input up.
// ----------------------------------------------------------------------------
module tb_meter_response_frame_checker;
	import mrfc_pkg::*;

	typedef enum logic [1:0] {TRL_NONE, TRL_GOOD, TRL_BAD} trailer_t;
	typedef enum logic [1:0] {FILL_ZERO, FILL_ONES, FILL_COUNT, FILL_RAND} fill_t;

	typedef struct {
		int       len;
		bit       addr_ok;
		trailer_t trl;
		fill_t    fill;
		bit       typed;    // status below is the known answer
		status_t  st;
	} frame_row_t;

	typedef struct {
		bit      typed;
		status_t st;
	} frame_plan_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata = 8'h00;   // rx_byte
	logic         s_axis_tlast = 1'b0;    // last_byte
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	// voltage, current, power, energy, frequency, power_factor, alarm
	logic [143:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;           // status
	logic         cfg_we = 1'b0;
	logic [7:0]   cfg_wdata = 8'h00;

	meter_response_frame_checker dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// decoder state, follows the words the block takes
	logic [7:0]  pred_addr = 8'd1;
	int          rx_count = 0;
	logic [15:0] rx_crc = CRC_INIT;
	logic [7:0]  rx_first = 8'h00;
	meas_t       rx_meas = '0;

	result_t     readings_due[$];
	frame_plan_t frame_plan[$];
	logic [7:0]  tx_bytes[$];

	logic [7:0]  cur_addr = 8'd1;
	bit          idle_on = 1'b0;
	int          burst_left = 0;
	bit          backpressure_req = 1'b0;
	int          hold_left = 0;
	int          rx_mode = 0;
	int          rx_mode_left = 0;

	int          fail_cnt = 0;
	int          bytes_taken = 0;
	int          frames_sent = 0;
	int          results_checked = 0;
	int          status_seen[4] = '{0, 0, 0, 0};
	int          long_holds = 0;

	result_t     predicted;
	result_t     want;
	result_t     got;
	frame_plan_t plan;

	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	// returns 1 on the last byte of a frame, with the decoded reading
	function automatic bit absorb_byte(input logic [7:0] b, input logic l, output result_t r);
		if (rx_count < MAX_FRAME) begin
			rx_crc = crc16_step(rx_crc, b);
			case (rx_count)
				0:              rx_first = b;
				3, 4:           rx_meas.voltage = {rx_meas.voltage[7:0], b};
				5, 6:           rx_meas.current = {rx_meas.current[7:0], b};
				7, 8, 9, 10:    rx_meas.power = {rx_meas.power[23:0], b};
				11, 12, 13, 14: rx_meas.energy = {rx_meas.energy[23:0], b};
				17, 18:         rx_meas.frequency = {rx_meas.frequency[7:0], b};
				19, 20:         rx_meas.power_factor = {rx_meas.power_factor[7:0], b};
				21, 22:         rx_meas.alarm = {rx_meas.alarm[7:0], b};
				default:        ;
			endcase
			rx_count++;
		end
		r = '0;
		if (!l)
			return 1'b0;
		if (rx_count < MIN_FRAME)
			r.status = ST_SHORT;
		else if (rx_first != pred_addr)
			r.status = ST_ADDR_ERR;
		else if (rx_crc != 16'h0000)
			r.status = ST_CRC_ERR;
		else
			r.status = ST_OK;
		r.meas = (r.status == ST_OK) ? rx_meas : '0;
		rx_count = 0;
		rx_crc = CRC_INIT;
		rx_first = 8'h00;
		rx_meas = '0;
		return 1'b1;
	endfunction

	function automatic void check_field(input string what, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, act_v);
			fail_cnt++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				pred_addr = cfg_wdata;
			if (m_axis_tvalid && m_axis_tready) begin
				got.status = status_t'(m_axis_tuser);
				got.meas = meas_t'(m_axis_tdata);
				if (readings_due.size() == 0) begin
					$display("%0t: result word with none pending, got status %0d", $time,
						got.status);
					fail_cnt++;
				end else begin
					want = readings_due.pop_front();
					check_field("status", want.status, got.status);
					check_field("voltage", want.meas.voltage, got.meas.voltage);
					check_field("current", want.meas.current, got.meas.current);
					check_field("power", want.meas.power, got.meas.power);
					check_field("energy", want.meas.energy, got.meas.energy);
					check_field("frequency", want.meas.frequency, got.meas.frequency);
					check_field("power_factor", want.meas.power_factor,
						got.meas.power_factor);
					check_field("alarm", want.meas.alarm, got.meas.alarm);
					status_seen[want.status]++;
				end
				results_checked++;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				bytes_taken++;
				if (absorb_byte(s_axis_tdata, s_axis_tlast, predicted)) begin
					plan = frame_plan.pop_front();
					if (plan.typed) begin
						predicted.status = plan.st;
						predicted.meas = '0;
					end
					readings_due.push_back(predicted);
				end
			end
		end
	end

	// receiver: mixes of always ready, coin flip and mostly ready, plus one long hold
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready = 1'b0;
			end else if (backpressure_req) begin
				backpressure_req = 1'b0;
				hold_left = 400;
				long_holds++;
				m_axis_tready = 1'b0;
			end else begin
				if (rx_mode_left == 0) begin
					rx_mode = $urandom_range(0, 2);
					rx_mode_left = $urandom_range(20, 200);
				end
				rx_mode_left--;
				case (rx_mode)
					0:       m_axis_tready = 1'b1;
					1:       m_axis_tready = 1'($urandom_range(0, 1));
					default: m_axis_tready = ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic l);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = idle_on ? $urandom_range(1, 6) : 0;
		end
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid = 1'b0;
			s_axis_tdata = 8'($urandom_range(0, 255));
			s_axis_tlast = 1'($urandom_range(0, 1));
		end
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata = b;
		s_axis_tlast = l;
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
	endtask

	function automatic logic [7:0] fill_byte(input fill_t f, input int k);
		case (f)
			FILL_ZERO:  return 8'h00;
			FILL_ONES:  return 8'hFF;
			FILL_COUNT: return k[7:0];
			default:    return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_frame(input frame_row_t row);
		int          span;
		int          body;
		int          k;
		logic [15:0] c;
		frame_plan_t p;
		tx_bytes.delete();
		span = (row.len > MAX_FRAME) ? MAX_FRAME : row.len;
		body = (row.trl == TRL_NONE || span < 3) ? row.len : span - 2;
		for (k = 0; k < body; k++) begin
			if (k == 0)
				tx_bytes.push_back(row.addr_ok ? cur_addr
					: cur_addr ^ 8'($urandom_range(1, 255)));
			else
				tx_bytes.push_back(fill_byte(row.fill, k));
		end
		if (body != row.len) begin
			c = CRC_INIT;
			foreach (tx_bytes[i])
				c = crc16_step(c, tx_bytes[i]);
			// trailer goes out low byte first
			tx_bytes.push_back(c[7:0]);
			tx_bytes.push_back(c[15:8]);
			// one flipped bit past the address always breaks the crc
			if (row.trl == TRL_BAD) begin
				k = $urandom_range(1, body + 1);
				tx_bytes[k] = tx_bytes[k] ^ 8'(1 << $urandom_range(0, 7));
			end
			for (k = span; k < row.len; k++)
				tx_bytes.push_back(fill_byte(row.fill, k));
		end
		p.typed = row.typed;
		p.st = row.st;
		frame_plan.push_back(p);
		foreach (tx_bytes[i])
			push_byte(tx_bytes[i], i == tx_bytes.size() - 1);
		frames_sent++;
	endtask

	task automatic send_random_frame();
		frame_row_t row;
		int         pick;
		pick = $urandom_range(0, 99);
		row.addr_ok = 1'b1;
		row.trl = TRL_GOOD;
		row.typed = 1'b0;
		row.st = ST_OK;
		row.len = ($urandom_range(0, 3) == 0) ? $urandom_range(23, 40) : 25;
		if (pick < 55) begin
		end else if (pick < 65) begin
			row.trl = TRL_BAD;
		end else if (pick < 75) begin
			row.addr_ok = 1'b0;
		end else if (pick < 85) begin
			row.len = $urandom_range(1, 22);
			row.trl = $urandom_range(0, 1) ? TRL_GOOD : TRL_NONE;
		end else if (pick < 90) begin
			row.len = ($urandom_range(0, 4) == 0) ? $urandom_range(250, 300)
				: $urandom_range(126, 160);
		end else begin
			row.len = $urandom_range(1, 40);
			row.trl = TRL_NONE;
			row.addr_ok = 1'($urandom_range(0, 1));
		end
		pick = $urandom_range(0, 9);
		row.fill = (pick == 0) ? FILL_ZERO : (pick == 1) ? FILL_ONES : FILL_RAND;
		idle_on = ($urandom_range(0, 3) != 0);
		send_frame(row);
	endtask

	// frame boundary: nothing in flight, nothing pending, pipeline drained
	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (readings_due.size() != 0 || frame_plan.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_address(input logic [7:0] a);
		cfg_we = 1'b1;
		cfg_wdata = a;
		@(negedge clk);
		cfg_we = 1'b0;
		cur_addr = a;
		burst_left = 0;
	endtask

	frame_row_t directed_rows[13] = '{
		'{1,   1'b1, TRL_NONE, FILL_ZERO,  1'b1, ST_SHORT},
		'{22,  1'b1, TRL_GOOD, FILL_RAND,  1'b1, ST_SHORT},
		'{22,  1'b0, TRL_BAD,  FILL_ONES,  1'b1, ST_SHORT},
		'{23,  1'b0, TRL_GOOD, FILL_RAND,  1'b1, ST_ADDR_ERR},
		'{25,  1'b0, TRL_BAD,  FILL_ONES,  1'b1, ST_ADDR_ERR},
		'{25,  1'b1, TRL_BAD,  FILL_RAND,  1'b1, ST_CRC_ERR},
		'{23,  1'b1, TRL_GOOD, FILL_ZERO,  1'b0, ST_OK},
		'{25,  1'b1, TRL_GOOD, FILL_ONES,  1'b0, ST_OK},
		'{25,  1'b1, TRL_GOOD, FILL_COUNT, 1'b0, ST_OK},
		'{128, 1'b1, TRL_GOOD, FILL_RAND,  1'b0, ST_OK},
		'{129, 1'b1, TRL_GOOD, FILL_RAND,  1'b0, ST_OK},
		'{300, 1'b1, TRL_GOOD, FILL_ONES,  1'b0, ST_OK},
		'{30,  1'b1, TRL_NONE, FILL_RAND,  1'b0, ST_OK}
	};

	logic [7:0] phase_addr[4];
	int         phase_bytes;

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed frames under the reset address
		foreach (directed_rows[i]) begin
			idle_on = i[0];
			send_frame(directed_rows[i]);
		end
		wait_idle();

		phase_addr = '{8'h00, 8'hFF, 8'($urandom_range(0, 255)), 8'h01};
		foreach (phase_addr[p]) begin
			set_address(phase_addr[p]);
			if (p == 0)
				backpressure_req = 1'b1;
			phase_bytes = 0;
			while (phase_bytes < 110) begin
				send_random_frame();
				phase_bytes += tx_bytes.size();
			end
			wait_idle();
		end
		repeat (6) @(negedge clk);

		$display("run: %0d frames, %0d bytes taken, %0d result words, %0d long holds",
			frames_sent, bytes_taken, results_checked, long_holds);
		$display("status mix: ok %0d, short %0d, address %0d, crc %0d; %0d mismatches",
			status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_ADDR_ERR],
			status_seen[ST_CRC_ERR], fail_cnt);
		if (fail_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/mrfc_pkg.sv
rtl/core/mrfc_crc16.sv
rtl/core/mrfc_frame_acc.sv
rtl/core/meter_response_frame_checker.sv
verif/tb_meter_response_frame_checker.sv
